### rtl/rtccal_pkg.sv
// Shared types and constants for the two-digit-year calendar clock.
// No dependencies; rtccal_step and rtc_calendar_with_remote_sync import this package.
`default_nettype none

package rtccal_pkg;

   // calendar time held by the clock
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } cal_type;

   // one request word as seen by the update logic
   typedef struct packed {
      logic        func;
      cal_type     set_time;
      logic        source_remote;
      logic [31:0] now_ms;
   } req_type;

   // everything the update logic hands back for one word
   typedef struct packed {
      cal_type     cal;
      logic        remote_flag;
      logic [31:0] last_sync_ms;
      logic        set_accepted;
   } step_type;

   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_SET  = 1'b1
   } func_type;

   typedef enum logic [0:0] {
      CSR_ZONE_OFFSET     = 1'b0,
      CSR_RESYNC_INTERVAL = 1'b1
   } csr_index_type;

   localparam logic [4:0]  ZONE_OFFSET_RESET     = 5'd8;
   localparam logic [31:0] RESYNC_INTERVAL_RESET = 32'd3600000;

   localparam cal_type CAL_RESET = '{
      year:   7'd18,
      month:  4'd6,
      day:    5'd15,
      hour:   5'd20,
      minute: 6'd30,
      second: 6'd0
   };

   localparam logic [6:0] YEAR_MAX   = 7'd99;
   localparam logic [3:0] MONTH_MAX  = 4'd12;
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;
   localparam logic [5:0] SECOND_MAX = 6'd59;
   localparam logic [5:0] HOURS_DAY  = 6'd24;

endpackage

`default_nettype wire

### rtl/rtccal_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; widths follow the calendar field widths.
`default_nettype none

interface rtccal_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [6:0]  set_year;
   logic [3:0]  set_month;
   logic [4:0]  set_day;
   logic [4:0]  set_hour;
   logic [5:0]  set_minute;
   logic [5:0]  set_second;
   logic        source_remote;
   logic [31:0] now_ms;

   modport source (
      output valid, func, set_year, set_month, set_day, set_hour,
             set_minute, set_second, source_remote, now_ms,
      input  ready
   );
   modport sink (
      input  valid, func, set_year, set_month, set_day, set_hour,
             set_minute, set_second, source_remote, now_ms,
      output ready
   );
endinterface

interface rtccal_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic        synced_remote;
   logic        set_accepted;

   modport source (
      output valid, year, month, day, hour, minute, second,
             synced_remote, set_accepted,
      input  ready
   );
   modport sink (
      input  valid, year, month, day, hour, minute, second,
             synced_remote, set_accepted,
      output ready
   );
endinterface

`default_nettype wire

### rtl/rtccal_step.sv
// Next-state logic of the calendar: one-second tick or validated set.
// Depends on rtccal_pkg.
`default_nettype none

module rtccal_step import rtccal_pkg::*; (
   input  wire cal_type     cal,
   input  wire logic        remote_flag,
   input  wire logic [31:0] last_sync_ms,
   input  wire logic [4:0]  zone_offset_hours,
   input  wire logic [31:0] resync_interval_ms,
   input  wire req_type     req,
   output step_type         step
);

   function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:   len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic cal_type advance_day(input cal_type c);
      cal_type r;
      r = c;
      if (c.day >= month_length(c.month, c.year)) begin
         r.day = 5'd1;
         if (c.month >= MONTH_MAX) begin
            r.month = 4'd1;
            r.year  = (c.year >= YEAR_MAX) ? 7'd0 : c.year + 7'd1;
         end else begin
            r.month = c.month + 4'd1;
         end
      end else begin
         r.day = c.day + 5'd1;
      end
      return r;
   endfunction

   cal_type     tick_cal;
   cal_type     load_cal;
   cal_type     set_cal;
   logic [31:0] elapsed;
   logic        consider;
   logic        valid_set;
   logic [4:0]  off;
   logic [5:0]  hour_sum;
   cal_type     st;

   // carry chain for a tick
   always_comb begin
      tick_cal = cal;
      if (cal.second >= SECOND_MAX) begin
         tick_cal.second = 6'd0;
         if (cal.minute >= MINUTE_MAX) begin
            tick_cal.minute = 6'd0;
            if (cal.hour >= HOUR_MAX) begin
               tick_cal.hour = 5'd0;
               tick_cal      = advance_day(tick_cal);
            end else begin
               tick_cal.hour = cal.hour + 5'd1;
            end
         end else begin
            tick_cal.minute = cal.minute + 6'd1;
         end
      end else begin
         tick_cal.second = cal.second + 6'd1;
      end
   end

   // set request: window check, range check, zone shift
   always_comb begin
      st        = req.set_time;
      elapsed   = req.now_ms - last_sync_ms;
      consider  = (!remote_flag && req.source_remote) || (elapsed > resync_interval_ms);
      valid_set = (st.year <= YEAR_MAX) && (st.month >= 4'd1) && (st.month <= MONTH_MAX) &&
                  (st.day >= 5'd1) && (st.day <= month_length(st.month, st.year)) &&
                  (st.hour <= HOUR_MAX) && (st.minute <= MINUTE_MAX) &&
                  (st.second <= SECOND_MAX);
      off       = (zone_offset_hours > HOUR_MAX) ? HOUR_MAX : zone_offset_hours;
      hour_sum  = {1'b0, st.hour} + {1'b0, off};
      load_cal  = st;
      if (hour_sum >= HOURS_DAY) begin
         load_cal.hour = 5'(hour_sum - HOURS_DAY);
         set_cal       = advance_day(load_cal);
      end else begin
         load_cal.hour = hour_sum[4:0];
         set_cal       = load_cal;
      end
   end

   always_comb begin
      step.cal          = cal;
      step.remote_flag  = remote_flag;
      step.last_sync_ms = last_sync_ms;
      step.set_accepted = 1'b0;
      case (func_type'(req.func))
         FUNC_TICK: begin
            step.cal = tick_cal;
         end
         FUNC_SET: begin
            if (consider && valid_set) begin
               step.cal          = set_cal;
               step.remote_flag  = req.source_remote;
               step.last_sync_ms = req.now_ms;
               step.set_accepted = 1'b1;
            end
         end
         default: begin
            step.cal = cal;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/rtc_calendar_with_remote_sync.sv
// Calendar clock with remote sync; the response to each taken word is registered.
// Throughput: one word per cycle; the calendar state is updated in the same
// cycle as the word is taken, and the result waits in a single output register.
// req ready drops only while that register holds a word that is not taken.
// Reset (synchronous, active high): 18-06-15 20:30:00, local, zone 8 h, 3600000 ms.
`default_nettype none

module rtc_calendar_with_remote_sync import rtccal_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   rtccal_req_if.sink       req_ch,
   rtccal_rsp_if.source     rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // configuration registers
   logic [4:0]  zone_offset_ff;
   logic [31:0] resync_interval_ff;

   // calendar state
   cal_type     cal_ff;
   logic        remote_flag_ff;
   logic [31:0] last_sync_ff;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   step_type    rsp_ff;

   req_type     req_word;
   step_type    step;
   logic        req_take;

   // a word is taken whenever the output register is free or being emptied
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign req_word.func              = req_ch.func;
   assign req_word.set_time.year     = req_ch.set_year;
   assign req_word.set_time.month    = req_ch.set_month;
   assign req_word.set_time.day      = req_ch.set_day;
   assign req_word.set_time.hour     = req_ch.set_hour;
   assign req_word.set_time.minute   = req_ch.set_minute;
   assign req_word.set_time.second   = req_ch.set_second;
   assign req_word.source_remote     = req_ch.source_remote;
   assign req_word.now_ms            = req_ch.now_ms;

   rtccal_step u_step (
      .cal                (cal_ff),
      .remote_flag        (remote_flag_ff),
      .last_sync_ms       (last_sync_ff),
      .zone_offset_hours  (zone_offset_ff),
      .resync_interval_ms (resync_interval_ff),
      .req                (req_word),
      .step               (step)
   );

   // csr writes must only arrive while idle; the block does not enforce this and has no interlock with the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff     <= ZONE_OFFSET_RESET;
         resync_interval_ff <= RESYNC_INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ZONE_OFFSET:     zone_offset_ff     <= csr_wdata[4:0];
            CSR_RESYNC_INTERVAL: resync_interval_ff <= csr_wdata;
            default:             zone_offset_ff     <= zone_offset_ff;
         endcase
      end
   end

   // calendar state loads the step result with each taken word
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff         <= CAL_RESET;
         remote_flag_ff <= 1'b0;
         last_sync_ff   <= 32'd0;
      end else if (req_take) begin
         cal_ff         <= step.cal;
         remote_flag_ff <= step.remote_flag;
         last_sync_ff   <= step.last_sync_ms;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= step;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.year          = rsp_ff.cal.year;
   assign rsp_ch.month         = rsp_ff.cal.month;
   assign rsp_ch.day           = rsp_ff.cal.day;
   assign rsp_ch.hour          = rsp_ff.cal.hour;
   assign rsp_ch.minute        = rsp_ff.cal.minute;
   assign rsp_ch.second        = rsp_ff.cal.second;
   assign rsp_ch.synced_remote = rsp_ff.remote_flag;
   assign rsp_ch.set_accepted  = rsp_ff.set_accepted;

endmodule

`default_nettype wire
